>>> src/rdf_pkg.sv
// Shared types, codes and defaults for the report deframer with ring FIFO.
// No dependencies; every other file in src uses this package.
`default_nettype none

package rdf_pkg;

  localparam int unsigned RING_DEPTH_DEF   = 2048;
  localparam int unsigned REPORT_BYTES_DEF = 64;
  localparam int unsigned BYTE_W           = 8;
  localparam int unsigned FILL_W           = 11;
  // holds a saturated payload length (at most 61)
  localparam int unsigned CNT_W            = 6;

  localparam logic [BYTE_W-1:0] CODE_GOOD = 8'hBB;
  localparam logic [BYTE_W-1:0] CODE_BAD  = 8'hAA;

  typedef enum logic [1:0] {
    FUNC_BYTE  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_REJECT  = 3'd2,
    ST_READ_OK = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_CLEARED = 3'd5
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [BYTE_W-1:0] read_byte;
    logic              reply_sent;
    logic [BYTE_W-1:0] reply_code;
    logic [FILL_W-1:0] fill_level;
  } out_t;

  // request classes handed from the front to the back
  typedef enum logic [2:0] {
    CMD_PLAIN = 3'd0,
    CMD_GOOD  = 3'd1,
    CMD_BAD   = 3'd2,
    CMD_READ  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef struct packed {
    cmd_e              op;
    logic [CNT_W-1:0]  count;
    logic              reply_sent;
    logic [BYTE_W-1:0] reply_code;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_PUSH   = 2'd1,
    BK_RDWAIT = 2'd2,
    BK_RESP   = 2'd3
  } back_state_e;

endpackage

`default_nettype wire

>>> src/rdf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on rdf_pkg for parameter defaults.
`default_nettype none

module rdf_ram #(
  parameter int unsigned WIDTH = rdf_pkg::BYTE_W,
  parameter int unsigned DEPTH = rdf_pkg::RING_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/rdf_front.sv
// Front end: takes requests, tracks report position and check XOR, stages
// payload bytes and classifies each request for the back end. Uses rdf_pkg.
`default_nettype none

module rdf_front #(
  parameter int unsigned REPORT_BYTES = rdf_pkg::REPORT_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rdf_pkg::in_t                      in_i,
  output logic                              cmd_valid_o,
  input  logic                              cmd_ready_i,
  output rdf_pkg::cmd_t                     cmd_o,
  input  logic                              commit_done_i,
  output logic                              stg_we_o,
  output logic [$clog2(REPORT_BYTES-3)-1:0] stg_waddr_o,
  output logic [rdf_pkg::BYTE_W-1:0]        stg_wdata_o
);

  import rdf_pkg::*;

  localparam int unsigned PAY_MAX = REPORT_BYTES - 3;
  localparam int unsigned PW      = $clog2(REPORT_BYTES);
  localparam int unsigned SAW     = $clog2(PAY_MAX);
  localparam logic [PW-1:0] LAST_POS  = PW'(REPORT_BYTES - 1);
  localparam logic [PW-1:0] LEN_POS   = PW'(1);
  localparam logic [PW-1:0] FIRST_PAY = PW'(2);

  logic [PW-1:0]     pos_q, pos_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic [BYTE_W-1:0] len_q, len_d;
  logic              busy_q, busy_d;
  logic              reply_en_q;

  logic              is_byte, is_last, pay_pos, hold, accept, good;
  logic [BYTE_W-1:0] len_sat;

  always_comb begin
    is_byte = (in_i.func == FUNC_BYTE);
    is_last = (pos_q == LAST_POS);
    pay_pos = (pos_q >= FIRST_PAY) && !is_last;
    // a commit still reads staging: hold payload bytes of the next report
    hold    = busy_q && is_byte && pay_pos;
    in_ready_o  = cmd_ready_i && !hold;
    cmd_valid_o = in_valid_i && !hold;
    accept  = in_valid_i && in_ready_o;
    good    = (in_i.data_byte == xor_q);
    len_sat = (len_q > BYTE_W'(PAY_MAX)) ? BYTE_W'(PAY_MAX) : len_q;
  end

  always_comb begin
    cmd_o.op         = CMD_PLAIN;
    cmd_o.count      = len_sat[CNT_W-1:0];
    cmd_o.reply_sent = 1'b0;
    cmd_o.reply_code = '0;
    unique case (in_i.func)
      FUNC_BYTE: begin
        if (is_last) begin
          cmd_o.op         = good ? CMD_GOOD : CMD_BAD;
          cmd_o.reply_sent = reply_en_q;
          if (reply_en_q) begin
            cmd_o.reply_code = good ? CODE_GOOD : CODE_BAD;
          end
        end
      end
      FUNC_READ:  cmd_o.op = CMD_READ;
      FUNC_CLEAR: cmd_o.op = CMD_CLEAR;
      FUNC_NOP:   cmd_o.op = CMD_PLAIN;
    endcase
  end

  always_comb begin
    pos_d  = pos_q;
    xor_d  = xor_q;
    len_d  = len_q;
    busy_d = busy_q;
    if (commit_done_i) begin
      busy_d = 1'b0;
    end
    if (accept && is_byte) begin
      if (is_last) begin
        pos_d = '0;
        xor_d = '0;
        len_d = '0;
        if (good) begin
          busy_d = 1'b1;
        end
      end else begin
        xor_d = xor_q ^ in_i.data_byte;
        pos_d = pos_q + PW'(1);
        if (pos_q == LEN_POS) begin
          len_d = in_i.data_byte;
        end
      end
    end
  end

  assign stg_we_o    = accept && is_byte && pay_pos;
  assign stg_waddr_o = SAW'(pos_q - FIRST_PAY);
  assign stg_wdata_o = in_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      xor_q      <= '0;
      len_q      <= '0;
      busy_q     <= 1'b0;
      reply_en_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      xor_q  <= xor_d;
      len_q  <= len_d;
      busy_q <= busy_d;
      if (cfg_we_i) begin
        reply_en_q <= cfg_wdata_i;
      end
    end
  end

`ifndef SYNTH
  // staging must never be overwritten while a commit may still read it
  a_no_stage_wr_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_we_o |-> !busy_q)
    else $error("staging written during commit");
`endif

endmodule

`default_nettype wire

>>> src/rdf_cmd_queue.sv
// Two-entry request queue between the front and back ends.
// Uses rdf_pkg for the request type.
`default_nettype none

module rdf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rdf_pkg::cmd_t push_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rdf_pkg::cmd_t pop_o
);

  import rdf_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_q] <= push_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

>>> src/rdf_back.sv
// Back end: carries out requests against the ring FIFO, commits staged
// payloads byte by byte and holds the result register. Uses rdf_pkg.
`default_nettype none

module rdf_back #(
  parameter int unsigned RING_DEPTH   = rdf_pkg::RING_DEPTH_DEF,
  parameter int unsigned REPORT_BYTES = rdf_pkg::REPORT_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cmd_valid_i,
  output logic                              cmd_ready_o,
  input  rdf_pkg::cmd_t                     cmd_i,
  output logic                              commit_done_o,
  output logic [$clog2(REPORT_BYTES-3)-1:0] stg_raddr_o,
  input  logic [rdf_pkg::BYTE_W-1:0]        stg_rdata_i,
  output logic                              ring_we_o,
  output logic [$clog2(RING_DEPTH)-1:0]     ring_waddr_o,
  output logic [rdf_pkg::BYTE_W-1:0]        ring_wdata_o,
  output logic [$clog2(RING_DEPTH)-1:0]     ring_raddr_o,
  input  logic [rdf_pkg::BYTE_W-1:0]        ring_rdata_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rdf_pkg::out_t                     out_o
);

  import rdf_pkg::*;

  localparam int unsigned RW  = $clog2(RING_DEPTH);
  localparam int unsigned SAW = $clog2(REPORT_BYTES - 3);
  localparam logic [RW-1:0] PTR_LAST = RW'(RING_DEPTH - 1);
  localparam logic [RW:0]   DEPTH_W  = (RW + 1)'(RING_DEPTH);

  back_state_e       state_q, state_d;
  logic [RW-1:0]     rp_q, rp_d, wp_q, wp_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              dv_q, dv_d;
  cmd_t              cmd_q, cmd_d;
  logic [BYTE_W-1:0] rbyte_q, rbyte_d;
  status_e           status_q, status_d;
  out_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              out_free, take, push_done, load;
  status_e           ld_status;
  logic [BYTE_W-1:0] ld_byte;
  cmd_t              ld_cmd;
  logic [RW-1:0]     push_nxt;
  logic [RW:0]       fill_w;
  logic [31:0]       fill32;

  function automatic logic [RW-1:0] ptr_next(input logic [RW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + RW'(1);
  endfunction

  function automatic logic [RW:0] fill_of(input logic [RW-1:0] rp,
                                          input logic [RW-1:0] wp);
    if (wp >= rp) begin
      return {1'b0, wp} - {1'b0, rp};
    end
    return DEPTH_W - {1'b0, rp} + {1'b0, wp};
  endfunction

  assign out_free  = !out_valid_q || out_ready_i;
  assign take      = (state_q == BK_IDLE) && cmd_valid_i && out_free;
  assign push_done = (idx_q == cmd_q.count) && !dv_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (take) begin
          if (cmd_i.op == CMD_GOOD) begin
            state_d = BK_PUSH;
          end else if (cmd_i.op == CMD_READ && rp_q != wp_q) begin
            state_d = BK_RDWAIT;
          end
        end
      end
      BK_PUSH: begin
        if (push_done) begin
          state_d = BK_RESP;
        end
      end
      BK_RDWAIT: state_d = BK_RESP;
      BK_RESP: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_ready_o   = 1'b0;
    commit_done_o = 1'b0;
    ring_we_o     = 1'b0;
    ring_waddr_o  = wp_q;
    ring_wdata_o  = stg_rdata_i;
    ring_raddr_o  = rp_q;
    stg_raddr_o   = idx_q[SAW-1:0];
    rp_d      = rp_q;
    wp_d      = wp_q;
    idx_d     = idx_q;
    dv_d      = dv_q;
    cmd_d     = cmd_q;
    rbyte_d   = rbyte_q;
    status_d  = status_q;
    load      = 1'b0;
    ld_status = status_q;
    ld_byte   = rbyte_q;
    ld_cmd    = cmd_q;
    push_nxt  = ptr_next(wp_q);
    unique case (state_q)
      BK_IDLE: begin
        cmd_ready_o = out_free;
        if (take) begin
          cmd_d   = cmd_i;
          idx_d   = '0;
          dv_d    = 1'b0;
          rbyte_d = '0;
          ld_cmd  = cmd_i;
          ld_byte = '0;
          unique case (cmd_i.op)
            CMD_GOOD: status_d = ST_ACCEPT;
            CMD_BAD: begin
              load      = 1'b1;
              ld_status = ST_REJECT;
            end
            CMD_CLEAR: begin
              rp_d      = '0;
              wp_d      = '0;
              load      = 1'b1;
              ld_status = ST_CLEARED;
            end
            CMD_READ: begin
              if (rp_q == wp_q) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                // ring read address is rp_q this cycle
                rp_d     = ptr_next(rp_q);
                status_d = ST_READ_OK;
              end
            end
            default: begin
              load      = 1'b1;
              ld_status = ST_TAKEN;
            end
          endcase
        end
      end
      BK_PUSH: begin
        // staging read issued the cycle before its ring push
        dv_d = (idx_q != cmd_q.count);
        if (idx_q != cmd_q.count) begin
          idx_d = idx_q + CNT_W'(1);
        end
        if (dv_q) begin
          if (push_nxt == rp_q) begin
            // ring full: drop the byte and restart both pointers
            rp_d = '0;
            wp_d = '0;
          end else begin
            ring_we_o = 1'b1;
            wp_d      = push_nxt;
          end
        end
        commit_done_o = push_done;
      end
      BK_RDWAIT: rbyte_d = ring_rdata_i;
      BK_RESP:   load = out_free;
    endcase

    fill_w = fill_of(rp_d, wp_d);
    fill32 = 32'(fill_w);
    out_d  = out_q;
    if (load) begin
      out_d.status     = ld_status;
      out_d.read_byte  = ld_byte;
      out_d.reply_sent = ld_cmd.reply_sent;
      out_d.reply_code = ld_cmd.reply_code;
      out_d.fill_level = fill32[FILL_W-1:0];
    end
    out_valid_d = load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      idx_q       <= '0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      idx_q       <= idx_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    rbyte_q  <= rbyte_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTH
  a_push_only_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PUSH |-> cmd_q.op == CMD_GOOD)
    else $error("commit running for a request that is not a good report");
  a_idx_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PUSH |-> idx_q <= cmd_q.count)
    else $error("commit index ran past payload length");
  a_ring_wr_in_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we_o |-> state_q == BK_PUSH && dv_q)
    else $error("ring written outside a commit");
  a_rdwait_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_RDWAIT |-> $past(state_q) == BK_IDLE)
    else $error("read wait not entered from idle");
`endif

endmodule

`default_nettype wire

>>> src/report_deframer_ring_fifo.sv
// Report deframer with ring FIFO: 64-byte XOR-checked reports in, payload out.
// Report bytes, rejects, clears and empty reads load the result register when taken;
//   a read that returns data first waits for the ring read; a committing report end
//   first commits its payload, one payload byte per cycle from staging.
// Throughput: one request per cycle unless a read, a commit or out_ready_i stalls it.
// Reset: rst_ni asynchronous, active low, clears control state; memories need no clearing.
`default_nettype none

module report_deframer_ring_fifo #(
  parameter int unsigned RING_DEPTH   = rdf_pkg::RING_DEPTH_DEF,
  parameter int unsigned REPORT_BYTES = rdf_pkg::REPORT_BYTES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // reply_enable register
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  // request channel
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rdf_pkg::in_t  in_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rdf_pkg::out_t out_o
);

  import rdf_pkg::*;

  localparam int unsigned PAY_MAX = REPORT_BYTES - 3;
  localparam int unsigned SAW     = $clog2(PAY_MAX);
  localparam int unsigned RW      = $clog2(RING_DEPTH);

  // front -> queue
  logic              fq_valid, fq_ready;
  cmd_t              fq_cmd;
  // queue -> back
  logic              qb_valid, qb_ready;
  cmd_t              qb_cmd;
  // back tells front that staging is free again
  logic              commit_done;

  // staging buffer: written by the front, read by the back during a commit
  logic              stg_we;
  logic [SAW-1:0]    stg_waddr, stg_raddr;
  logic [BYTE_W-1:0] stg_wdata, stg_rdata;

  // ring store: written only by commits, read only by read requests
  logic              ring_we;
  logic [RW-1:0]     ring_waddr, ring_raddr;
  logic [BYTE_W-1:0] ring_wdata, ring_rdata;

  // Front: position/XOR tracking, payload staging, request classification.
  // It holds off payload bytes of the next report while a commit is running.
  rdf_front #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .cmd_valid_o   (fq_valid),
    .cmd_ready_i   (fq_ready),
    .cmd_o         (fq_cmd),
    .commit_done_i (commit_done),
    .stg_we_o      (stg_we),
    .stg_waddr_o   (stg_waddr),
    .stg_wdata_o   (stg_wdata)
  );

  rdf_cmd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_i       (fq_cmd),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_o        (qb_cmd)
  );

  // Back: ring pointers, commit sequencer and the result register.
  rdf_back #(
    .RING_DEPTH   (RING_DEPTH),
    .REPORT_BYTES (REPORT_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (qb_valid),
    .cmd_ready_o   (qb_ready),
    .cmd_i         (qb_cmd),
    .commit_done_o (commit_done),
    .stg_raddr_o   (stg_raddr),
    .stg_rdata_i   (stg_rdata),
    .ring_we_o     (ring_we),
    .ring_waddr_o  (ring_waddr),
    .ring_wdata_o  (ring_wdata),
    .ring_raddr_o  (ring_raddr),
    .ring_rdata_i  (ring_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_o)
  );

  rdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (PAY_MAX)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (stg_we),
    .waddr_i (stg_waddr),
    .wdata_i (stg_wdata),
    .raddr_i (stg_raddr),
    .rdata_o (stg_rdata)
  );

  rdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

endmodule

`default_nettype wire
